// ===== rtl/core/pnd_pkg.sv =====
// shared constants, types and table builder for the 2d gradient noise block
// depends on nothing; used by pnd_grad and perlin_noise_2d
package pnd_pkg;

  localparam int ANGLE_BITS   = 10;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam longint CORDIC_GAIN = 652032874;

  // hash multipliers
  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;

  // angle table is stored for one quadrant only
  localparam int QUAD_BITS = ANGLE_BITS - 2;
  localparam int QUAD_SIZE = 1 << QUAD_BITS;

  // arctangent per cordic step, in 2^-32 turn
  localparam longint ATAN_TURN [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } grad_t;

  // entry: {c, s, -c, -s}, each rounded half up to q1.15
  typedef logic [63:0] tab_t [QUAD_SIZE];

  function automatic logic [15:0] to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r < -32767) r = -32767;
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  function automatic logic [63:0] grad_entry(int r);
    longint c;
    longint s;
    longint z;
    longint t;
    z = longint'(r) * (longint'(1) << (32 - ANGLE_BITS)) - longint'(536870912);
    c = CORDIC_GAIN;
    s = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = c - (s >>> i);
        s = s + (c >>> i);
        z = z - ATAN_TURN[i];
      end else begin
        t = c + (s >>> i);
        s = s - (c >>> i);
        z = z + ATAN_TURN[i];
      end
      c = t;
    end
    return {to_q15(c), to_q15(s), to_q15(-c), to_q15(-s)};
  endfunction

  function automatic tab_t build_tab();
    tab_t tb;
    for (int r = 0; r < QUAD_SIZE; r++) begin
      tb[r] = grad_entry(r);
    end
    return tb;
  endfunction

endpackage

// ===== rtl/core/pnd_grad.sv =====
// gradient lookup: hash word to q1.15 unit gradient
// depends on pnd_pkg (table builder, grad_t)
module pnd_grad (
  input  logic [31:0]   hash,
  output pnd_pkg::grad_t grad
);

  localparam int AB = pnd_pkg::ANGLE_BITS;
  localparam int QB = pnd_pkg::QUAD_BITS;
  localparam pnd_pkg::tab_t GRAD_TAB = pnd_pkg::build_tab();

  logic [AB-1:0] shifted;
  logic [1:0]    quad;
  logic [QB-1:0] idx;
  logic [63:0]   ent;
  logic [15:0]   pc;
  logic [15:0]   ps;
  logic [15:0]   nc;
  logic [15:0]   ns;

  // phase shifted by one eighth turn, split into quadrant and residual
  assign shifted = hash[31 -: AB] + AB'(1 << (AB - 3));
  assign quad    = shifted[AB-1 -: 2];
  assign idx     = shifted[QB-1:0];
  assign ent     = GRAD_TAB[idx];
  assign {pc, ps, nc, ns} = ent;

  // quadrant rotation
  always_comb begin
    case (quad)
      2'd0: begin
        grad.gx = pc;
        grad.gy = ps;
      end
      2'd1: begin
        grad.gx = ns;
        grad.gy = pc;
      end
      2'd2: begin
        grad.gx = nc;
        grad.gy = ns;
      end
      default: begin
        grad.gx = ps;
        grad.gy = nc;
      end
    endcase
  end

endmodule

// ===== rtl/core/perlin_noise_2d.sv =====
// top level of the 2d gradient noise pipeline
// depends on pnd_pkg and pnd_grad
//
// input channel: in_valid/in_ready carry one point word (x_coord, y_coord),
// signed fixed point with FRAC_BITS fraction bits
// output channel: out_valid/out_ready carry one result word (noise, pixel)
// a point moves through stages 1 to 8 in order; out_valid rises when it
// reaches stage 8; one word per cycle when nothing stalls; eight register
// stages, set by the chain of three hash multipliers, table lookup, offset
// times gradient, dot product and two blends
// each stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and in_ready stays high
// while any stage is free
// reset clears all valid bits; data registers are not reset
// when the receiver stalls the last stage holds its word and the stages
// behind fill up, then in_ready drops; nothing is lost or repeated
module perlin_noise_2d (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] noise,
  output logic        [7:0]  pixel
);

  localparam int FB   = pnd_pkg::FRAC_BITS;
  localparam int TW   = FB + 6;
  localparam int PW   = FB + 17;
  localparam int DW   = 18;
  localparam int RW   = DW + 1;
  localparam int NSTG = 8;
  localparam logic signed [TW-1:0] ONE_T = TW'(1 << FB);

  // fade step: floor(t*w) + add
  function automatic logic signed [TW-1:0] fade_step(logic signed [TW-1:0] t,
      logic [FB-1:0] w, logic signed [TW-1:0] add);
    logic signed [TW+FB:0] p;
    p = t * $signed({1'b0, w});
    return TW'(p >>> FB) + add;
  endfunction

  function automatic logic [31:0] rot16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // stage handshake
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: cell split, first hash multiply, fade start
  logic [31:0]           x0_in;
  logic [31:0]           y0_in;
  logic [31:0]           s1_a0;
  logic [31:0]           s1_a1;
  logic [31:0]           s1_y0;
  logic [31:0]           s1_y1;
  logic [FB-1:0]         s1_fx;
  logic [FB-1:0]         s1_fy;
  logic signed [TW-1:0]  s1_tx;
  logic signed [TW-1:0]  s1_ty;

  assign x0_in = 32'(x_coord >>> FB);
  assign y0_in = 32'(y_coord >>> FB);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_a0 <= x0_in * pnd_pkg::HASH_K1;
      s1_a1 <= (x0_in + 32'd1) * pnd_pkg::HASH_K1;
      s1_y0 <= y0_in;
      s1_y1 <= y0_in + 32'd1;
      s1_fx <= x_coord[FB-1:0];
      s1_fy <= y_coord[FB-1:0];
      s1_tx <= TW'(6) * $signed({{(TW-FB){1'b0}}, x_coord[FB-1:0]}) - TW'(15) * ONE_T;
      s1_ty <= TW'(6) * $signed({{(TW-FB){1'b0}}, y_coord[FB-1:0]}) - TW'(15) * ONE_T;
    end
  end

  // stage 2: second hash multiply per corner; corners are x0y0, x1y0, x0y1, x1y1
  logic [31:0]          s2_b [4];
  logic [31:0]          s2_a0;
  logic [31:0]          s2_a1;
  logic [FB-1:0]        s2_fx;
  logic [FB-1:0]        s2_fy;
  logic signed [TW-1:0] s2_tx;
  logic signed [TW-1:0] s2_ty;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_b[0] <= (s1_y0 ^ rot16(s1_a0)) * pnd_pkg::HASH_K2;
      s2_b[1] <= (s1_y0 ^ rot16(s1_a1)) * pnd_pkg::HASH_K2;
      s2_b[2] <= (s1_y1 ^ rot16(s1_a0)) * pnd_pkg::HASH_K2;
      s2_b[3] <= (s1_y1 ^ rot16(s1_a1)) * pnd_pkg::HASH_K2;
      s2_a0   <= s1_a0;
      s2_a1   <= s1_a1;
      s2_fx   <= s1_fx;
      s2_fy   <= s1_fy;
      s2_tx   <= fade_step(s1_tx, s1_fx, TW'(10) * ONE_T);
      s2_ty   <= fade_step(s1_ty, s1_fy, TW'(10) * ONE_T);
    end
  end

  // stage 3: final hash multiply
  logic [31:0]          s3_h [4];
  logic [FB-1:0]        s3_fx;
  logic [FB-1:0]        s3_fy;
  logic signed [TW-1:0] s3_tx;
  logic signed [TW-1:0] s3_ty;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_h[0] <= (s2_a0 ^ rot16(s2_b[0])) * pnd_pkg::HASH_K3;
      s3_h[1] <= (s2_a1 ^ rot16(s2_b[1])) * pnd_pkg::HASH_K3;
      s3_h[2] <= (s2_a0 ^ rot16(s2_b[2])) * pnd_pkg::HASH_K3;
      s3_h[3] <= (s2_a1 ^ rot16(s2_b[3])) * pnd_pkg::HASH_K3;
      s3_fx   <= s2_fx;
      s3_fy   <= s2_fy;
      s3_tx   <= fade_step(s2_tx, s2_fx, '0);
      s3_ty   <= fade_step(s2_ty, s2_fy, '0);
    end
  end

  // stage 4: gradient lookup
  pnd_pkg::grad_t       grad_c [4];
  pnd_pkg::grad_t       s4_g [4];
  logic [FB-1:0]        s4_fx;
  logic [FB-1:0]        s4_fy;
  logic signed [TW-1:0] s4_tx;
  logic signed [TW-1:0] s4_ty;

  for (genvar c = 0; c < 4; c++) begin : g_corner
    pnd_grad u_grad (
      .hash (s3_h[c]),
      .grad (grad_c[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 4; c++) s4_g[c] <= grad_c[c];
      s4_fx <= s3_fx;
      s4_fy <= s3_fy;
      s4_tx <= fade_step(s3_tx, s3_fx, '0);
      s4_ty <= fade_step(s3_ty, s3_fy, '0);
    end
  end

  // stage 5: offset times gradient, last fade step with clamp
  logic signed [FB:0]   dx [2];
  logic signed [FB:0]   dy [2];
  logic signed [TW-1:0] tx5;
  logic signed [TW-1:0] ty5;
  logic signed [PW-1:0] s5_px [4];
  logic signed [PW-1:0] s5_py [4];
  logic [FB:0]          s5_sx;
  logic [FB:0]          s5_sy;

  // fx-1 is the fraction with a sign bit set
  assign dx[0] = $signed({1'b0, s4_fx});
  assign dx[1] = $signed({1'b1, s4_fx});
  assign dy[0] = $signed({1'b0, s4_fy});
  assign dy[1] = $signed({1'b1, s4_fy});
  assign tx5   = fade_step(s4_tx, s4_fx, '0);
  assign ty5   = fade_step(s4_ty, s4_fy, '0);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 4; c++) begin
        s5_px[c] <= PW'(dx[c % 2]) * PW'(s4_g[c].gx);
        s5_py[c] <= PW'(dy[c / 2]) * PW'(s4_g[c].gy);
      end
      s5_sx <= (tx5 < 0) ? '0 : ((tx5 > ONE_T) ? (FB+1)'(ONE_T) : (FB+1)'(tx5));
      s5_sy <= (ty5 < 0) ? '0 : ((ty5 > ONE_T) ? (FB+1)'(ONE_T) : (FB+1)'(ty5));
    end
  end

  // stage 6: dot product rounded half up
  logic signed [PW:0]   dot_sum [4];
  logic signed [DW-1:0] s6_dot [4];
  logic [FB:0]          s6_sx;
  logic [FB:0]          s6_sy;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dot_sum[c] = (PW+1)'(s5_px[c]) + (PW+1)'(s5_py[c]) + (PW+1)'(1 << (FB - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 4; c++) s6_dot[c] <= DW'(dot_sum[c] >>> FB);
      s6_sx <= s5_sx;
      s6_sy <= s5_sy;
    end
  end

  // stage 7: blend along x
  logic signed [DW:0]      dif_x [2];
  logic signed [DW+FB+2:0] prd_x [2];
  logic signed [RW-1:0]    s7_r [2];
  logic [FB:0]             s7_sy;

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      dif_x[j] = (DW+1)'(s6_dot[2*j+1]) - (DW+1)'(s6_dot[2*j]);
      prd_x[j] = dif_x[j] * $signed({1'b0, s6_sx});
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 2; j++) begin
        s7_r[j] <= RW'(s6_dot[2*j]) + RW'(prd_x[j] >>> FB);
      end
      s7_sy <= s6_sy;
    end
  end

  // stage 8: blend along y, saturate, pixel
  logic signed [RW:0]      dif_y;
  logic signed [RW+FB+2:0] prd_y;
  logic signed [RW+1:0]    nsum;
  logic signed [15:0]      nsat;
  logic signed [8:0]       pix_raw;

  always_comb begin
    dif_y = (RW+1)'(s7_r[1]) - (RW+1)'(s7_r[0]);
    prd_y = dif_y * $signed({1'b0, s7_sy});
    nsum  = (RW+2)'(s7_r[0]) + (RW+2)'(prd_y >>> FB);
    if (nsum < -32768) nsat = -16'sd32768;
    else if (nsum > 32767) nsat = 16'sd32767;
    else nsat = 16'(nsum);
    pix_raw = 9'(nsat >>> 8) + 9'sd127;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      noise <= nsat;
      pixel <= (pix_raw < 0) ? 8'd0 : pix_raw[7:0];
    end
  end

endmodule

// ===== tb/perlin_noise_2d_test.sv =====
// self-checking testbench for the 2d gradient noise block perlin_noise_2d
// depends on pnd_pkg (widths) and the perlin_noise_2d rtl
`timescale 1ns / 1ps

module perlin_noise_2d_test;

  localparam int ANGLE_BITS     = pnd_pkg::ANGLE_BITS;
  localparam int FRAC_BITS      = pnd_pkg::FRAC_BITS;
  localparam int TIMEOUT_CYCLES = 5000;
  localparam int DRAIN_CYCLES   = 20;

  // traffic shapes per phase
  typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic signed [15:0] noise;
    logic        [7:0]  pixel;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] noise;
  logic [7:0] pixel;

  point_t point_q[$];
  shade_t shade_q[$];
  phase_t phase = PH_FREE;
  bit     hold_src = 1'b0;
  bit     src_done = 1'b0;
  int     errors = 0;
  int     quiet_cycles = 0;

  always #6 clk = ~clk;

  perlin_noise_2d DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_coord(x_coord), .y_coord(y_coord),
    .out_valid(out_valid), .out_ready(out_ready),
    .noise(noise), .pixel(pixel)
  );

  // gradient hash of one lattice corner
  function automatic logic [31:0] lattice_hash(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] a;
    logic [31:0] b;
    a = ix * 32'd3284157443;
    b = iy ^ {a[15:0], a[31:16]};
    b = b * 32'd1911520717;
    a = a ^ {b[15:0], b[31:16]};
    a = a * 32'd2048419325;
    return a;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r < -32767) r = -32767;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  // corner gradient dotted with the offset, rounded to q.15
  function automatic longint corner_slope(logic [31:0] ix, logic [31:0] iy,
                                          longint dx, longint dy);
    longint atan_tab [16];
    logic [31:0] ph;
    logic [31:0] sh;
    logic [1:0] quad;
    longint z, c, s, t, gx, gy;
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                 83443, 41722, 20861};
    ph = lattice_hash(ix, iy) & (32'hFFFF_FFFF << (32 - ANGLE_BITS));
    sh = ph + 32'h2000_0000;
    quad = sh[31:30];
    z = longint'({2'b00, sh[29:0]}) - 64'sh2000_0000;
    c = 652032874;
    s = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = c - (s >>> i);
        s = s + (c >>> i);
        z = z - atan_tab[i];
      end else begin
        t = c + (s >>> i);
        s = s - (c >>> i);
        z = z + atan_tab[i];
      end
      c = t;
    end
    case (quad)
      2'd0: begin gx = c; gy = s; end
      2'd1: begin gx = -s; gy = c; end
      2'd2: begin gx = -c; gy = -s; end
      default: begin gx = s; gy = -c; end
    endcase
    gx = round_q15(gx);
    gy = round_q15(gy);
    return (dx * gx + dy * gy + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // quintic ease curve, clamped to [0,1]
  function automatic longint ease(longint w);
    longint unit, t;
    unit = longint'(1) << FRAC_BITS;
    t = 6 * w - 15 * unit;
    t = ((t * w) >>> FRAC_BITS) + 10 * unit;
    t = (t * w) >>> FRAC_BITS;
    t = (t * w) >>> FRAC_BITS;
    t = (t * w) >>> FRAC_BITS;
    if (t < 0) t = 0;
    if (t > unit) t = unit;
    return t;
  endfunction

  function automatic longint mix(longint a0, longint a1, longint f);
    return a0 + (((a1 - a0) * f) >>> FRAC_BITS);
  endfunction

  function automatic shade_t predict_shade(point_t p);
    longint unit, fx, fy, sx, sy, r0, r1, nv, pv;
    logic [31:0] x0, y0, x1, y1;
    shade_t res;
    unit = longint'(1) << FRAC_BITS;
    x0 = 32'(p.x >>> FRAC_BITS);
    y0 = 32'(p.y >>> FRAC_BITS);
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    fx = longint'(p.x) & (unit - 1);
    fy = longint'(p.y) & (unit - 1);
    sx = ease(fx);
    sy = ease(fy);
    r0 = mix(corner_slope(x0, y0, fx, fy), corner_slope(x1, y0, fx - unit, fy), sx);
    r1 = mix(corner_slope(x0, y1, fx, fy - unit),
             corner_slope(x1, y1, fx - unit, fy - unit), sx);
    nv = mix(r0, r1, sy);
    if (nv < -32768) nv = -32768;
    if (nv > 32767) nv = 32767;
    pv = (nv >>> 8) + 127;
    if (pv < 0) pv = 0;
    if (pv > 255) pv = 255;
    res.noise = nv[15:0];
    res.pixel = pv[7:0];
    return res;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic bit src_idles(phase_t ph);
    return (ph == PH_SRC_IDLE) ? chance(61) : (ph == PH_BOTH) ? chance(9) : 1'b0;
  endfunction

  function automatic bit snk_stalls(phase_t ph);
    return (ph == PH_SNK_STALL) ? chance(61) : (ph == PH_BOTH) ? chance(9) : 1'b0;
  endfunction

  // driver: holds the word until it is taken, then maybe presents the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) shade_q.push_back(predict_shade('{x_coord, y_coord}));
      if (point_q.size() > 0 && !hold_src && !src_idles(phase)) begin
        point_t p;
        p = point_q.pop_front();
        x_coord  <= p.x;
        y_coord  <= p.y;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (shade_q.size() == 0) begin
          $display("%0t: unexpected result noise=%0d pixel=%0d", $time, noise, pixel);
          errors++;
        end else begin
          shade_t e;
          e = shade_q.pop_front();
          if (noise !== e.noise) begin
            $display("%0t: noise expected %0d actual %0d", $time, e.noise, noise);
            errors++;
          end
          if (pixel !== e.pixel) begin
            $display("%0t: pixel expected %0d actual %0d", $time, e.pixel, pixel);
            errors++;
          end
        end
      end
      out_ready <= !snk_stalls(phase);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= TIMEOUT_CYCLES && !src_done) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand32();
    return $urandom();
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    point_q.push_back('{x, y});
  endtask

  // wait until the driver has sent everything and all results are back
  task automatic drain();
    while (point_q.size() > 0 || in_valid || shade_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, lattice points, near-one fractions, wrapping corners
    add_point(32'h0000_0000, 32'h0000_0000);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_point(32'h0000_FFFF, 32'h0000_0001);
    add_point(32'h0000_8000, 32'h0000_8000);
    add_point(32'hFFFF_0000, 32'h0001_0000);
    add_point(32'h7FFF_0000, 32'hFFFF_8000);
    add_point(32'h5555_5555, 32'hAAAA_AAAA);
    add_point(32'hAAAA_AAAA, 32'h5555_5555);
    for (int i = 0; i < 8; i++) add_point(32'(i) << 14, 32'(7 - i) << 14);
    drain();

    // random phases, each with a different traffic shape
    for (int ph = 0; ph < 4; ph++) begin
      phase = phase_t'(ph);
      for (int n = 0; n < 100; n++) begin
        if (chance(60)) add_point(rand32() >> $urandom_range(31, 8), -(rand32() >> 12));
        else add_point(rand32(), rand32());
      end
      if (ph == 1) begin
        // sender holds off until the pipeline has drained
        repeat (40) @(posedge clk);
        hold_src = 1'b1;
        while (in_valid || shade_q.size() > 0) @(posedge clk);
        hold_src = 1'b0;
      end
      drain();
    end

    src_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && shade_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
